@@ rtl/core/wmpa_pkg.sv @@
// types and constants shared by the warp map pixel accumulate unit
`default_nettype none

package wmpa_pkg;

    localparam int AXES = 2;

    // exact scale: one pixel is 255 * 256 sub-units
    localparam logic signed [18:0] UNIT_S = 19'sd65280;
    localparam logic [16:0]        UNIT_U = 17'd65280;

    typedef enum logic [1:0] {
        CFG_CROP_LEFT   = 2'd0,
        CFG_CROP_TOP    = 2'd1,
        CFG_CROP_WIDTH  = 2'd2,
        CFG_CROP_HEIGHT = 2'd3
    } t_cfg_index;

    // raw map bytes and gated shift of one axis
    typedef struct packed {
        logic [7:0]         mag;
        logic [7:0]         frac;
        logic signed [16:0] shift;
    } t_axis_raw;

    // integer part and unnormalised remainder
    typedef struct packed {
        logic signed [10:0] k;
        logic signed [18:0] r;
    } t_axis_kr0;

    // floor integer part and remainder in 0 .. UNIT-1
    typedef struct packed {
        logic signed [10:0] k;
        logic [15:0]        r;
    } t_axis_kr;

    typedef struct packed {
        logic [7:0] mag;
        logic [7:0] frac;
        logic       sat;
    } t_axis_enc;

endpackage

`default_nettype wire

@@ rtl/core/warp_map_pixel_accumulate_unit.sv @@
// warp map pixel accumulate unit: decode, add crop-gated shift, re-encode
//
// Input channel (i_in_valid / o_in_ready) carries one map pixel: position,
// the x and y magnitude and fraction bytes, and a signed shift per axis in
// 1/256 pixel. Output channel (o_out_valid / i_out_ready) carries the new
// magnitude and fraction bytes and a saturation flag, one result per pixel,
// in order. The shift is added only inside the crop rectangle, which the user
// must write through the write port (i_cfg_we, i_cfg_index, i_cfg_wdata)
// only while idle; the block itself does not enforce it. Four register
// stages: region check, split into integer and remainder, remainder
// normalise, re-encode into the output register. One pixel per cycle is
// taken whenever the output side keeps up.
// When the receiver stalls, the stages fill up in turn and o_in_ready drops
// only once all four hold a pixel; nothing is dropped or repeated.
// A synchronous active-low reset empties the pipeline and clears the crop
// registers, so no pixel gets a shift until the rectangle is written.
`default_nettype none

module warp_map_pixel_accumulate_unit #(
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_wdata,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [12:0]        i_column,
    input  wire logic [11:0]        i_row,
    input  wire logic [7:0]         i_x_magnitude_in,
    input  wire logic [7:0]         i_x_fraction_in,
    input  wire logic [7:0]         i_y_magnitude_in,
    input  wire logic [7:0]         i_y_fraction_in,
    input  wire logic signed [16:0] i_shift_x,
    input  wire logic signed [16:0] i_shift_y,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_x_magnitude_out,
    output logic [7:0]              o_x_fraction_out,
    output logic [7:0]              o_y_magnitude_out,
    output logic [7:0]              o_y_fraction_out,
    output logic                    o_saturated
);

    import wmpa_pkg::*;

    localparam logic [14:0] LIM_W = 15'(MAX_WIDTH);
    localparam logic [14:0] LIM_H = 15'(MAX_HEIGHT);

    // crop registers
    logic [12:0] r_crop_left;
    logic [11:0] r_crop_top;
    logic [13:0] r_crop_width;
    logic [12:0] r_crop_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_left   <= '0;
            r_crop_top    <= '0;
            r_crop_width  <= '0;
            r_crop_height <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CROP_LEFT:   r_crop_left   <= i_cfg_wdata[12:0];
                CFG_CROP_TOP:    r_crop_top    <= i_cfg_wdata[11:0];
                CFG_CROP_WIDTH:  r_crop_width  <= i_cfg_wdata;
                CFG_CROP_HEIGHT: r_crop_height <= i_cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4        = !r_v4 || i_out_ready;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: crop test and shift gating
    logic      in_region;
    logic [12:0] col_off;
    logic [11:0] row_off;
    t_axis_raw n_s1 [AXES];
    t_axis_raw r_s1 [AXES];

    always_comb begin
        col_off   = i_column - r_crop_left;
        row_off   = i_row - r_crop_top;
        in_region = ({2'b00, i_column} < LIM_W) && ({3'b000, i_row} < LIM_H)
                 && (i_column >= r_crop_left) && ({1'b0, col_off} < r_crop_width)
                 && (i_row >= r_crop_top) && ({1'b0, row_off} < r_crop_height);
        n_s1[0].mag   = i_x_magnitude_in;
        n_s1[0].frac  = i_x_fraction_in;
        n_s1[0].shift = in_region ? i_shift_x : 17'sd0;
        n_s1[1].mag   = i_y_magnitude_in;
        n_s1[1].frac  = i_y_fraction_in;
        n_s1[1].shift = in_region ? i_shift_y : 17'sd0;
    end

    // stage 2: integer part and remainder in sub-units
    t_axis_kr0 n_s2 [AXES];
    t_axis_kr0 r_s2 [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_s2[a].k = (r_s1[a].frac[7] ? $signed({3'b000, r_s1[a].mag})
                                         : -$signed({3'b000, r_s1[a].mag}))
                      + $signed({{2{r_s1[a].shift[16]}}, r_s1[a].shift[16:8]});
            n_s2[a].r = $signed({2'b00, r_s1[a].frac, 9'b0})
                      + $signed({3'b000, r_s1[a].shift[7:0], 8'b0})
                      - $signed({11'b0, r_s1[a].shift[7:0]})
                      - UNIT_S;
        end
    end

    // stage 3: bring remainder into 0 .. UNIT-1
    t_axis_kr n_s3 [AXES];
    t_axis_kr r_s3 [AXES];
    logic signed [18:0] rem_adj [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (r_s2[a].r >= UNIT_S) begin
                n_s3[a].k  = r_s2[a].k + 11'sd1;
                rem_adj[a] = r_s2[a].r - UNIT_S;
            end else if (r_s2[a].r < 19'sd0) begin
                n_s3[a].k  = r_s2[a].k - 11'sd1;
                rem_adj[a] = r_s2[a].r + UNIT_S;
            end else begin
                n_s3[a].k  = r_s2[a].k;
                rem_adj[a] = r_s2[a].r;
            end
            n_s3[a].r = rem_adj[a][15:0];
        end
    end

    // stage 4: truncate toward zero and re-encode
    t_axis_enc n_s4 [AXES];
    t_axis_enc r_s4 [AXES];
    logic               neg [AXES];
    logic signed [10:0] trunc_int [AXES];
    logic [10:0]        trunc_abs [AXES];
    logic [16:0]        rem_up [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            neg[a]       = r_s3[a].k[10] && (r_s3[a].r != 16'd0);
            trunc_int[a] = neg[a] ? r_s3[a].k + 11'sd1 : r_s3[a].k;
            trunc_abs[a] = trunc_int[a][10] ? 11'(-trunc_int[a]) : 11'(trunc_int[a]);
            rem_up[a]    = {1'b0, r_s3[a].r} + UNIT_U;
            n_s4[a].sat  = trunc_abs[a] > 11'd255;
            n_s4[a].mag  = n_s4[a].sat ? 8'hFF : trunc_abs[a][7:0];
            n_s4[a].frac = neg[a] ? {1'b0, r_s3[a].r[15:9]} : rem_up[a][16:9];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
        if (en2) r_s2 <= n_s2;
        if (en3) r_s3 <= n_s3;
        if (en4) r_s4 <= n_s4;
    end

    assign o_out_valid       = r_v4;
    assign o_x_magnitude_out = r_s4[0].mag;
    assign o_x_fraction_out  = r_s4[0].frac;
    assign o_y_magnitude_out = r_s4[1].mag;
    assign o_y_fraction_out  = r_s4[1].frac;
    assign o_saturated       = r_s4[0].sat || r_s4[1].sat;

`ifndef ASSERT_OFF
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_v1 && r_v2 && r_v3))
        else $error("input stalled while pipeline has room");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_x_fraction_out != 8'hFF && o_y_fraction_out != 8'hFF))
        else $error("fraction code out of range");

    a_sat_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_x_magnitude_out == 8'hFF || o_y_magnitude_out == 8'hFF))
        else $error("saturation flag without a clamped magnitude");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire
